[rtl/hfe_pkg.sv]
// Package: types, constants and helpers shared by the Huffman encoder and bit packer.
package hfe_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int TOTAL_WIDTH  = 48;

  localparam int SYM_W       = 8;
  localparam int TABLE_DEPTH = 1 << SYM_W;
  localparam int LEN_W       = 6;
  localparam int WORD_W      = 32;
  localparam int WORD_LIMIT  = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;
  localparam int PEND_W      = 7;
  localparam int ACC_W       = PEND_W + WORD_W;
  localparam int CNT_W       = $clog2(ACC_W + 1);
  localparam int OUT_TOT_W   = 48;

  // Command queue between the table front end and the packer; depth is a power of two.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_len;
    logic [WORD_W-1:0] code_bits;
  } hfe_in_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 byte_valid;
    logic                 last;
    logic [OUT_TOT_W-1:0] total_bits;
  } hfe_out_t;

  // One queued job for the packer: a code to append, or a flush.
  typedef struct packed {
    logic              flush;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] word;
  } hfe_cmd_t;

  // Keeps the low len bits of a code word.
  function automatic logic [WORD_W-1:0] code_mask(input logic [LEN_W-1:0] len);
    logic [WORD_W-1:0] m;
    if (len >= LEN_W'(WORD_W)) m = '1;
    else                       m = ~({WORD_W{1'b1}} << len);
    return m;
  endfunction

endpackage

[rtl/hfe_front.sv]
// Front end: accepts input beats, owns the code tables, queues encode and flush jobs.
module hfe_front import hfe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  hfe_in_t  in_data_i,
  output logic     push_o,
  output hfe_cmd_t push_cmd_o,
  input  logic     q_full_i
);

  logic [WORD_W-1:0] word_mem [TABLE_DEPTH];
  logic [LEN_W-1:0]  len_mem  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] len_vld_q;

  logic              s1_valid_q, s1_valid_d;
  logic [1:0]        s1_op_q;
  logic [WORD_W-1:0] word_rd_q;
  logic [LEN_W-1:0]  len_rd_q;
  logic              lv_rd_q;

  logic              accept;
  logic              is_load;
  logic [LEN_W-1:0]  load_len;
  logic [LEN_W-1:0]  s1_len;
  logic              s1_job;

  assign accept  = in_valid_i && !in_stall_o;
  assign is_load = accept && (in_data_i.opcode == OP_LOAD);

  // Saturate overlong lengths.
  assign load_len = (in_data_i.code_len > LEN_W'(WORD_LIMIT)) ? LEN_W'(WORD_LIMIT)
                                                              : in_data_i.code_len;

  // Table write and registered read share the accept edge; at most one item per edge means no
  // read/write collision, and a load accepted on an earlier edge is already in the table.
  always_ff @(posedge clk_i) begin
    if (is_load) begin
      word_mem[in_data_i.symbol] <= in_data_i.code_bits & code_mask(load_len);
      len_mem[in_data_i.symbol]  <= load_len;
    end
    if (accept) begin
      word_rd_q <= word_mem[in_data_i.symbol];
      len_rd_q  <= len_mem[in_data_i.symbol];
      s1_op_q   <= in_data_i.opcode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_vld_q <= '0;
      lv_rd_q   <= 1'b0;
    end else begin
      if (is_load) len_vld_q[in_data_i.symbol] <= 1'b1;
      if (accept)  lv_rd_q <= len_vld_q[in_data_i.symbol];
    end
  end

  assign s1_len = lv_rd_q ? len_rd_q : '0;

  always_comb begin
    s1_job = 1'b0;
    case (s1_op_q)
      OP_ENCODE: s1_job = (s1_len != '0);
      OP_FLUSH:  s1_job = 1'b1;
      default:   s1_job = 1'b0;
    endcase
  end

  assign push_o           = s1_valid_q && s1_job && !q_full_i;
  assign push_cmd_o.flush = (s1_op_q == OP_FLUSH);
  assign push_cmd_o.len   = s1_len;
  assign push_cmd_o.word  = word_rd_q;

  assign in_stall_o = s1_valid_q && s1_job && q_full_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept)           s1_valid_d = 1'b1;
    else if (!in_stall_o) s1_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else         s1_valid_q <= s1_valid_d;
  end

endmodule

[rtl/hfe_fifo.sv]
// Short command queue between the front end and the packer.
module hfe_fifo import hfe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hfe_cmd_t push_cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output hfe_cmd_t head_o
);

  hfe_cmd_t          slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_cmd_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/hfe_packer.sv]
// Back end: bit accumulator, byte emission and the output register.
module hfe_packer import hfe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_empty_i,
  input  hfe_cmd_t head_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output hfe_out_t out_data_o
);

  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [TOTAL_WIDTH-1:0] bit_total_q, bit_total_d;
  logic                   out_valid_q, out_valid_d;
  hfe_out_t               out_q, out_d;

  logic                   out_ready;
  logic                   draining;
  logic [PEND_W-1:0]      pend;
  logic [7:0]             byte_sel;
  logic [PEND_W+7:0]      flush_wide;
  logic [ACC_W-1:0]       acc_shift;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign draining  = (cnt_q >= CNT_W'(8));

  // Pending bits when idle (count below 8); stale upper bits are masked off.
  assign pend = acc_q[PEND_W-1:0] &
                ((PEND_W'(1) << cnt_q[2:0]) - PEND_W'(1));

  assign acc_shift  = acc_q >> (cnt_q - CNT_W'(8));
  assign byte_sel   = acc_shift[7:0];
  assign flush_wide = {8'b0, pend} << (4'd8 - {1'b0, cnt_q[2:0]});

  always_comb begin
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    bit_total_d = bit_total_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    if (out_ready) out_valid_d = 1'b0;
    if (draining) begin
      if (out_ready) begin
        out_valid_d      = 1'b1;
        out_d.out_byte   = byte_sel;
        out_d.byte_valid = 1'b1;
        out_d.last       = (cnt_q < CNT_W'(16));
        out_d.total_bits = '0;
        cnt_d            = cnt_q - CNT_W'(8);
      end
    end else if (!q_empty_i) begin
      if (!head_i.flush) begin
        pop_o       = 1'b1;
        acc_d       = ({{WORD_W{1'b0}}, pend} << head_i.len) |
                      {{PEND_W{1'b0}}, head_i.word};
        cnt_d       = cnt_q + CNT_W'(head_i.len);
        bit_total_d = bit_total_q + {{(TOTAL_WIDTH-LEN_W){1'b0}}, head_i.len};
      end else if (out_ready) begin
        pop_o            = 1'b1;
        out_valid_d      = 1'b1;
        out_d.out_byte   = flush_wide[7:0];
        out_d.byte_valid = (cnt_q != '0);
        out_d.last       = 1'b1;
        out_d.total_bits = OUT_TOT_W'(bit_total_q);
        cnt_d            = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      bit_total_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      bit_total_q <= bit_total_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(ACC_W))
    else $error("bit count beyond accumulator");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.flush) |=> (cnt_q == '0))
    else $error("flush left pending bits");

  a_no_pop_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draining |-> !pop_o)
    else $error("job taken while bytes still pending");

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.byte_valid) |-> out_q.last)
    else $error("empty marker without last");

endmodule

[rtl/huffman_table_encoder_bit_packer.sv]
// Top level: Huffman table encoder with MSB-first bit packing.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one beat per unstalled cycle:
//   load writes a symbol's code into the 256-entry table, encode appends that
//   symbol's code, flush pads the pending bits with zeros and reports the total.
//   Output channel (out_valid_o / out_stall_i / out_data_o) carries one byte per
//   beat, first code bit in bit 7; last marks the final beat of an input item.
// Path: an encode's first output beat passes the table read, the queue write,
//   the accumulator load and the output register; a flush result passes the
//   table read, the queue write and the output register.
// Throughput: while out_stall_i is low the packer emits one byte per cycle and
//   loads a code only when no whole byte is pending; loads and zero-length
//   encodes are absorbed by the front end at one per cycle while in_stall_o is
//   low. The 4-entry queue lets the front keep accepting while the packer drains.
// Reset: clears the length table valid bits (unloaded symbols read as length
//   zero), the pending bit count, the bit total, the queue and all valid flags.
// Stall: a stalled output beat holds; the packer stops once it has a byte or a
//   flush to emit, the queue fills, and in_stall_o rises once a job finds the queue full.
module huffman_table_encoder_bit_packer import hfe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  hfe_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output hfe_out_t out_data_o
);

  logic     push;
  hfe_cmd_t push_cmd;
  logic     q_full;
  logic     q_empty;
  logic     pop;
  hfe_cmd_t head;

  // Table lookup and classification.
  hfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .q_full_i   (q_full)
  );

  // Decouples table lookups from byte emission.
  hfe_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  // Bit accumulator and output register.
  hfe_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
